/* sv/rcwt_pkg.sv */
// shared types and constants for the raycast wall texture column unit
package rcwt_pkg;

   // request kinds carried on the request tuser bit
   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   // configuration register indexes
   localparam logic [1:0] CSR_SCREEN_HEIGHT = 2'd0;
   localparam logic [1:0] CSR_TEXTURE_WIDTH = 2'd1;
   localparam logic [1:0] CSR_TEX_HEIGHT_LOG2 = 2'd2;

   // wall texture codes
   localparam logic [1:0] TEX_NORTH = 2'd0;
   localparam logic [1:0] TEX_SOUTH = 2'd1;
   localparam logic [1:0] TEX_WEST  = 2'd2;
   localparam logic [1:0] TEX_EAST  = 2'd3;

   // register reset values
   localparam logic [11:0] SCREEN_HEIGHT_RESET = 12'd480;
   localparam logic [10:0] TEXTURE_WIDTH_RESET = 11'd64;
   localparam logic [3:0]  TEX_HEIGHT_LOG2_RESET = 4'd6;

   localparam int DIV_STEPS = 32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_HIT,
      ST_FRAC,
      ST_COL,
      ST_DIV_WAIT,
      ST_POS
   } seq_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* sv/rcwt_divider.sv */
// restoring divider, one quotient bit per cycle, 32 by 16 bits
module rcwt_divider
   import rcwt_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [31:0]    dividend,
   input  logic [15:0]    divisor,
   output div_status_type status,
   output logic [31:0]    quotient
);

   logic [15:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [4:0]  count_ff, count_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;
   logic [16:0] diff;
   logic        fits;

   // a zero divisor always fits, so the quotient saturates to all ones
   assign trial = {rem_ff, quo_ff[31]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = '0;
         quo_in   = dividend;
         count_in = 5'(DIV_STEPS - 1);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[15:0] : trial[15:0];
         quo_in = {quo_ff[30:0], fits};
         count_in = count_ff - 5'd1;
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

/* sv/raycast_wall_texture_column_unit.sv */
// raycast wall texture column unit: column setup sequencer and pixel stepper
// pixel request: result registered in the cycle after acceptance, one pixel per cycle while the result is not stalled
// column load request: no result, request side held off while the setup runs and the
//   32-step restoring divider forms the texture step
// the output register lets a pixel request be taken while the previous result drains
// reset (synchronous, active high) clears all column state and restores register defaults
module raycast_wall_texture_column_unit
   import rcwt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_tvalid,
   output logic         req_tready,
   // viewer_x[23:0] viewer_y[47:24] ray_x[63:48] ray_y[79:64] distance[103:80]
   // side_hit[104] first_row[116:105] end_row[129:117] slice_height[145:130]
   // column_in[157:146] zero[159:158]
   input  logic [159:0] req_tdata,
   input  logic         req_tuser,   // command[0]
   // result channel
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // column_out[11:0] row_out[23:12] texture_select[25:24] texel_column[35:26]
   // texel_row[45:36] zero[47:46]
   output logic [47:0]  rsp_tdata,
   output logic         rsp_tlast,   // last_pixel
   // configuration write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [11:0]  csr_data
);

   // configuration registers
   logic [11:0] screen_height_ff;
   logic [10:0] texture_width_ff;
   logic [3:0]  tex_height_log2_ff;

   // sequencer
   seq_state_type state_ff, state_in;

   // captured column load request
   logic [15:0] view_x_lo_ff, view_y_lo_ff;
   logic signed [15:0] ray_x_ff, ray_y_ff;
   logic [23:0] dist_ff;
   logic        side_ff;
   logic [11:0] first_ff;
   logic [12:0] end_ff;
   logic [15:0] slice_h_ff;
   logic [11:0] col_load_ff;

   // setup intermediates
   logic [29:0] prod_lo_ff, prod_lo_in;
   logic [29:0] frac_ff, frac_in;
   logic signed [17:0] offset_ff, offset_in;
   logic [1:0]  sel_load_ff, sel_load_in;
   logic        mirror_ff, mirror_in;

   // column state
   logic [11:0] cur_column_ff, cur_column_in;
   logic [11:0] cur_row_ff, cur_row_in;
   logic [12:0] stop_row_ff, stop_row_in;
   logic [1:0]  side_choice_ff, side_choice_in;
   logic [9:0]  tex_column_ff, tex_column_in;
   logic [39:0] tex_position_ff, tex_position_in;
   logic [31:0] tex_increment_ff, tex_increment_in;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [45:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   // divider
   logic           div_start;
   logic [31:0]    div_dividend;
   div_status_type div_status;
   logic [31:0]    div_quotient;

   logic        req_accept;
   logic        load_accept;
   logic        pixel_accept;
   logic        pixel_live;
   logic        pixel_last;
   logic [9:0]  row_mask;
   logic signed [31:0] mul_a;
   logic signed [32:0] mul_b;
   logic signed [64:0] mul_prod;
   logic [10:0] tcol_raw;
   logic [10:0] tcol_mirror;
   logic signed [15:0] ray_pick;
   logic [15:0] view_pick;

   assign csr_ready    = 1'b1;
   assign req_tready   = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_accept   = req_tvalid && req_tready;
   assign load_accept  = req_accept && (req_tuser == CMD_LOAD);
   assign pixel_accept = req_accept && (req_tuser == CMD_PIXEL);

   // configuration writes, indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_height_ff   <= SCREEN_HEIGHT_RESET;
         texture_width_ff   <= TEXTURE_WIDTH_RESET;
         tex_height_log2_ff <= TEX_HEIGHT_LOG2_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SCREEN_HEIGHT:   screen_height_ff   <= csr_data;
            CSR_TEXTURE_WIDTH:   texture_width_ff   <= csr_data[10:0];
            CSR_TEX_HEIGHT_LOG2: tex_height_log2_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // texture step: (2^log2 << 16) / slice_height, starts with the load request
   assign div_start    = load_accept;
   assign div_dividend = 32'd1 << (5'(tex_height_log2_ff) + 5'd16);

   // divisor comes from the captured slice height, held for the whole division
   rcwt_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (slice_h_ff),
      .status   (div_status),
      .quotient (div_quotient)
   );

   // capture the load request
   always_ff @(posedge clock) begin
      if (load_accept) begin
         view_x_lo_ff <= req_tdata[15:0];
         view_y_lo_ff <= req_tdata[39:24];
         ray_x_ff     <= $signed(req_tdata[63:48]);
         ray_y_ff     <= $signed(req_tdata[79:64]);
         dist_ff      <= req_tdata[103:80];
         side_ff      <= req_tdata[104];
         first_ff     <= req_tdata[116:105];
         end_ff       <= req_tdata[129:117];
         slice_h_ff   <= req_tdata[145:130];
         col_load_ff  <= req_tdata[157:146];
      end
   end

   // hit coordinate only needs its low 30 bits (the fraction in Q.30)
   assign ray_pick  = side_ff ? ray_x_ff : ray_y_ff;
   assign view_pick = side_ff ? view_x_lo_ff : view_y_lo_ff;

   // one signed multiplier shared by the setup steps
   // hit: distance * ray, column: fraction * width, start: offset * step
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_MUL_HIT: begin
            mul_a = {{16{ray_pick[15]}}, ray_pick};
            mul_b = {9'd0, dist_ff};
         end
         ST_COL: begin
            mul_a = {2'd0, frac_ff};
            mul_b = {22'd0, texture_width_ff};
         end
         ST_POS: begin
            mul_a = {{14{offset_ff[17]}}, offset_ff};
            mul_b = {1'b0, div_quotient};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_prod = mul_a * mul_b;

   // texture column: (fraction * width) >> 30
   assign tcol_raw    = mul_prod[40:30];
   assign tcol_mirror = texture_width_ff - tcol_raw - 11'd1;

   // row mask, saturates at ten bits for tall textures
   assign row_mask = (tex_height_log2_ff >= 4'd10) ? '1
                   : 10'((11'd1 << tex_height_log2_ff) - 11'd1);

   assign pixel_live = {1'b0, cur_row_ff} < stop_row_ff;
   assign pixel_last = ({1'b0, cur_row_ff} + 13'd1) >= stop_row_ff;

   always_comb begin
      state_in         = state_ff;
      prod_lo_in       = prod_lo_ff;
      frac_in          = frac_ff;
      offset_in        = offset_ff;
      sel_load_in      = sel_load_ff;
      mirror_in        = mirror_ff;
      cur_column_in    = cur_column_ff;
      cur_row_in       = cur_row_ff;
      stop_row_in      = stop_row_ff;
      side_choice_in   = side_choice_ff;
      tex_column_in    = tex_column_ff;
      tex_position_in  = tex_position_ff;
      tex_increment_in = tex_increment_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_tready;
      rsp_data_in      = rsp_data_ff;
      rsp_last_in      = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (load_accept) begin
               state_in = ST_MUL_HIT;
            end else if (pixel_accept && pixel_live) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {tex_position_ff[25:16] & row_mask, tex_column_ff,
                               side_choice_ff, cur_row_ff, cur_column_ff};
               rsp_last_in  = pixel_last;
               tex_position_in = tex_position_ff + {8'd0, tex_increment_ff};
               if (pixel_last) begin
                  stop_row_in = '0;
               end else begin
                  cur_row_in = cur_row_ff + 12'd1;
               end
            end
         end
         ST_MUL_HIT: begin
            prod_lo_in = mul_prod[29:0];
            state_in   = ST_FRAC;
         end
         ST_FRAC: begin
            frac_in   = {view_pick, 14'd0} + prod_lo_ff;
            offset_in = $signed({6'd0, first_ff}) - $signed({7'd0, screen_height_ff[11:1]})
                      + $signed({3'd0, slice_h_ff[15:1]});
            // quadrant of the ray picks the wall face
            if (ray_x_ff <= 0 && ray_y_ff <= 0) begin
               sel_load_in = side_ff ? TEX_WEST : TEX_NORTH;
            end else if (ray_x_ff >= 0 && ray_y_ff >= 0) begin
               sel_load_in = side_ff ? TEX_EAST : TEX_SOUTH;
            end else if (ray_x_ff >= 0 && ray_y_ff <= 0) begin
               sel_load_in = side_ff ? TEX_WEST : TEX_SOUTH;
            end else begin
               sel_load_in = side_ff ? TEX_EAST : TEX_NORTH;
            end
            mirror_in = (side_ff && ray_y_ff < 0) || (!side_ff && ray_x_ff > 0);
            state_in  = ST_COL;
         end
         ST_COL: begin
            tex_column_in = mirror_ff ? tcol_mirror[9:0] : tcol_raw[9:0];
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_status.done) begin
               state_in = ST_POS;
            end
         end
         ST_POS: begin
            // starting texture position, kept modulo 2^40
            tex_increment_in = div_quotient;
            tex_position_in  = mul_prod[39:0];
            side_choice_in   = sel_load_ff;
            cur_column_in    = col_load_ff;
            cur_row_in       = first_ff;
            stop_row_in      = end_ff;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         rsp_valid_ff     <= 1'b0;
         cur_column_ff    <= '0;
         cur_row_ff       <= '0;
         stop_row_ff      <= '0;
         side_choice_ff   <= '0;
         tex_column_ff    <= '0;
         tex_position_ff  <= '0;
         tex_increment_ff <= '0;
      end else begin
         state_ff         <= state_in;
         rsp_valid_ff     <= rsp_valid_in;
         cur_column_ff    <= cur_column_in;
         cur_row_ff       <= cur_row_in;
         stop_row_ff      <= stop_row_in;
         side_choice_ff   <= side_choice_in;
         tex_column_ff    <= tex_column_in;
         tex_position_ff  <= tex_position_in;
         tex_increment_ff <= tex_increment_in;
      end
      prod_lo_ff  <= prod_lo_in;
      frac_ff     <= frac_in;
      offset_ff   <= offset_in;
      sel_load_ff <= sel_load_in;
      mirror_ff   <= mirror_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_data_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* sv/rcwt_checker.sv */
// port-level checks for the raycast wall texture column unit
module rcwt_checker
   import rcwt_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tuser,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [47:0]  rsp_tdata,
   input logic         rsp_tlast
);

   // stalled result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result changed");

   // a column load holds off the next request while the setup runs
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == CMD_LOAD) |=> !req_tready)
      else $error("request taken during column setup");

   // a new result only follows an accepted pixel request
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(req_tvalid && req_tready && (req_tuser == CMD_PIXEL)))
      else $error("result without pixel request");

   // no request is taken while a result is stuck
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken with result stalled");

endmodule

bind raycast_wall_texture_column_unit rcwt_checker u_rcwt_checker (.*);
